// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level regulator RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while aresetn is high.
`define PFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define PFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/pfd_pkg.sv -----
package pfd_pkg;

    localparam int GAIN_W             = 32;
    localparam int POLE_W             = 25;
    localparam int ACC_W              = 48;
    localparam int CFG_ADDR_W         = 4;
    localparam int CFG_DATA_W         = 32;
    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int SAMPLE_WIDTH_DEF   = 32;

    localparam logic OP_REGULATE    = 1'b0;
    localparam logic OP_CLEAR       = 1'b1;
    localparam logic KIND_DRIVE     = 1'b0;
    localparam logic KIND_CLEAR_ACK = 1'b1;

    localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [1:0] REG_DERIV_POLE    = 2'd2;
    localparam logic [1:0] REG_DERIV_GAIN    = 2'd3;

    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// ----- rtl/pfd_scaled_mul.sv -----
module pfd_scaled_mul import pfd_pkg::*; #(
    parameter int A_W  = GAIN_W,
    parameter int B_W  = ACC_W,
    parameter int FRAC = GAIN_FRAC_BITS_DEF
) (
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output acc_t                  q,
    output logic                  sat
);

    localparam int PROD_W = A_W + B_W;
    localparam int EXT_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W + 1;

    logic signed [PROD_W-1:0]      prod;
    logic signed [EXT_W-1:0]       prod_ext;
    logic signed [EXT_W-1:0]       shifted;
    logic        [EXT_W-ACC_W:0]   hi_bits;

    // The arithmetic shift rounds toward minus infinity.
    assign prod     = a * b;
    assign prod_ext = EXT_W'(prod);
    assign shifted  = prod_ext >>> FRAC;
    assign hi_bits  = shifted[EXT_W-1:ACC_W-1];
    assign sat      = !((&hi_bits) || !(|hi_bits));

    always_comb begin
        if (!sat) begin
            q = shifted[ACC_W-1:0];
        end else if (shifted[EXT_W-1]) begin
            q = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            q = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule

// ----- rtl/pid_filtered_derivative_top.sv -----
// PID regulator with a trapezoidal integral and a first-order filtered derivative.
// Input beats arrive on the s_ stream: tdata carries the signed error sample and
// tuser selects between regulating that sample and clearing the integral.
// Each input beat produces exactly one result beat on the m_ stream: the
// saturated drive value in tdata, and in tuser the result kind and a flag that
// reports any clipping in that step.
// Gains are written through the APB port; every register write also clears the
// previous error, the integral and the derivative state. Writes are to be made only
// while no beat is in flight; the block itself does not enforce this.
// An accepted beat passes the stage 1, 2 and 3 registers and the output register,
// and one beat is accepted per cycle when the receiver keeps up. That rate rests
// on the integral and derivative state being updated at once in the third stage.
// When the receiver stalls, results are held and the stages behind it fill in
// turn; s_tready drops only once all stages hold a beat.
// Reset clears the gains, the regulator state and all stage valids.
`include "assert_macros.svh"

module pid_filtered_derivative_top import pfd_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    localparam int DATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // error_sample
    input  logic [0:0]            s_tuser,   // opcode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // drive
    output logic [1:0]            m_tuser    // result_kind, saturated
);

    localparam int SUM_W   = SAMPLE_WIDTH + 1;
    localparam int DRIVE_W = ACC_W + 2;
    localparam int DHI_W   = ACC_W - GAIN_FRAC_BITS;
    localparam logic [31:0] POLE_ONE = 32'd1 << GAIN_FRAC_BITS;

    // Configuration registers.
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic        [POLE_W-1:0] pole_reg;
    logic signed [GAIN_W-1:0] kd_reg;

    // Regulator state.
    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    acc_t                           integ_reg;
    acc_t                           deriv_reg;

    // Stage valids and payloads.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic m_valid_reg;

    logic                           op1_reg;
    logic signed [SAMPLE_WIDTH-1:0] e1_reg;
    logic signed [SAMPLE_WIDTH-1:0] ep1_reg;

    logic op2_reg;
    acc_t p2_reg;
    acc_t inc2_reg;
    acc_t g2_reg;
    logic sat2_reg;

    logic op3_reg;
    acc_t p3_reg;
    logic sat3_reg;

    logic [SAMPLE_WIDTH-1:0] m_drive_reg;
    logic                    m_kind_reg;
    logic                    m_sat_reg;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic m_ready;
    logic in_accept;
    logic cfg_wr;
    logic [1:0] cfg_idx;

    logic signed [SUM_W-1:0] e_sum;
    logic signed [SUM_W-1:0] e_diff;
    acc_t p_q, inc_q, g_q, pole_q;
    logic p_sat, inc_sat, g_sat, pole_sat;

    logic        [POLE_W-1:0] pole_eff;
    logic signed [POLE_W:0]   pole_s;

    logic signed [DHI_W-1:0]        deriv_hi;
    logic signed [GAIN_FRAC_BITS:0] deriv_lo;
    acc_t pole_hi_q, pole_lo_q;
    logic pole_hi_sat, pole_lo_sat;

    logic signed [ACC_W:0] integ_sum;
    logic signed [ACC_W:0] deriv_sum;
    acc_t integ_next;
    acc_t deriv_next;
    logic integ_sat;
    logic deriv_sat;

    logic signed [DRIVE_W-1:0]        drive_sum;
    logic [DRIVE_W-SAMPLE_WIDTH:0]    drive_hi;
    logic                             drive_sat;
    logic [SAMPLE_WIDTH-1:0]          drive_clip;

    // Handshakes.
    assign m_ready   = !m_valid_reg || m_tready;
    assign s3_ready  = !s3_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_accept = s_tvalid && s1_ready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            REG_PROP_GAIN:     prdata = kp_reg;
            REG_INTEGRAL_GAIN: prdata = ki_reg;
            REG_DERIV_POLE:    prdata = CFG_DATA_W'(pole_reg);
            REG_DERIV_GAIN:    prdata = kd_reg;
            default:           prdata = '0;
        endcase
    end

    // Stage 2: products that depend only on the sample and the previous sample.
    assign e_sum  = SUM_W'(e1_reg) + SUM_W'(ep1_reg);
    assign e_diff = SUM_W'(e1_reg) - SUM_W'(ep1_reg);

    pfd_scaled_mul #(.A_W(GAIN_W), .B_W(SAMPLE_WIDTH), .FRAC(GAIN_FRAC_BITS)) u_mul_p (
        .a(kp_reg), .b(e1_reg), .q(p_q), .sat(p_sat)
    );
    pfd_scaled_mul #(.A_W(GAIN_W), .B_W(SUM_W), .FRAC(GAIN_FRAC_BITS)) u_mul_i (
        .a(ki_reg), .b(e_sum), .q(inc_q), .sat(inc_sat)
    );
    pfd_scaled_mul #(.A_W(GAIN_W), .B_W(SUM_W), .FRAC(GAIN_FRAC_BITS)) u_mul_d (
        .a(kd_reg), .b(e_diff), .q(g_q), .sat(g_sat)
    );

    // Stage 3: state update. A pole above one is taken as exactly one.
    assign pole_eff = (CFG_DATA_W'(pole_reg) > POLE_ONE) ? POLE_ONE[POLE_W-1:0] : pole_reg;
    assign pole_s   = {1'b0, pole_eff};

    // The derivative state is split at the binary point of the pole. The upper
    // part scales exactly, so the floor shift only applies to the lower part,
    // and with the pole at most one the sum always fits the accumulator.
    assign deriv_hi = deriv_reg[ACC_W-1:GAIN_FRAC_BITS];
    assign deriv_lo = {1'b0, deriv_reg[GAIN_FRAC_BITS-1:0]};

    pfd_scaled_mul #(.A_W(POLE_W + 1), .B_W(DHI_W), .FRAC(0)) u_mul_pole_hi (
        .a(pole_s), .b(deriv_hi), .q(pole_hi_q), .sat(pole_hi_sat)
    );
    pfd_scaled_mul #(.A_W(POLE_W + 1), .B_W(GAIN_FRAC_BITS + 1), .FRAC(GAIN_FRAC_BITS))
        u_mul_pole_lo (
        .a(pole_s), .b(deriv_lo), .q(pole_lo_q), .sat(pole_lo_sat)
    );

    assign pole_q   = pole_hi_q + pole_lo_q;
    assign pole_sat = pole_hi_sat || pole_lo_sat;

    assign integ_sum = (ACC_W + 1)'(integ_reg) + (ACC_W + 1)'(inc2_reg);
    assign deriv_sum = (ACC_W + 1)'(pole_q) + (ACC_W + 1)'(g2_reg);
    assign integ_sat = integ_sum[ACC_W] != integ_sum[ACC_W-1];
    assign deriv_sat = deriv_sum[ACC_W] != deriv_sum[ACC_W-1];

    always_comb begin
        if (!integ_sat) begin
            integ_next = integ_sum[ACC_W-1:0];
        end else begin
            integ_next = {integ_sum[ACC_W], {(ACC_W-1){!integ_sum[ACC_W]}}};
        end
        if (!deriv_sat) begin
            deriv_next = deriv_sum[ACC_W-1:0];
        end else begin
            deriv_next = {deriv_sum[ACC_W], {(ACC_W-1){!deriv_sum[ACC_W]}}};
        end
    end

    // Output stage: drive from the updated state.
    assign drive_sum = DRIVE_W'(p3_reg) + DRIVE_W'(integ_reg) + DRIVE_W'(deriv_reg);
    assign drive_hi  = drive_sum[DRIVE_W-1:SAMPLE_WIDTH-1];
    assign drive_sat = !((&drive_hi) || !(|drive_hi));

    always_comb begin
        if (!drive_sat) begin
            drive_clip = drive_sum[SAMPLE_WIDTH-1:0];
        end else begin
            drive_clip = {drive_sum[DRIVE_W-1], {(SAMPLE_WIDTH-1){!drive_sum[DRIVE_W-1]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            pole_reg     <= '0;
            kd_reg       <= '0;
            prev_reg     <= '0;
            integ_reg    <= '0;
            deriv_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_PROP_GAIN:     kp_reg   <= pwdata;
                    REG_INTEGRAL_GAIN: ki_reg   <= pwdata;
                    REG_DERIV_POLE:    pole_reg <= pwdata[POLE_W-1:0];
                    REG_DERIV_GAIN:    kd_reg   <= pwdata;
                    default:           kp_reg   <= kp_reg;
                endcase
                prev_reg  <= '0;
                integ_reg <= '0;
                deriv_reg <= '0;
            end else begin
                if (in_accept && s_tuser[0] == OP_REGULATE) begin
                    prev_reg <= s_tdata[SAMPLE_WIDTH-1:0];
                end
                if (s2_valid_reg && s3_ready) begin
                    if (op2_reg == OP_CLEAR) begin
                        integ_reg <= '0;
                    end else begin
                        integ_reg <= integ_next;
                        deriv_reg <= deriv_next;
                    end
                end
            end
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (m_ready) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            op1_reg <= s_tuser[0];
            e1_reg  <= s_tdata[SAMPLE_WIDTH-1:0];
            ep1_reg <= prev_reg;
        end
        if (s2_ready) begin
            op2_reg  <= op1_reg;
            p2_reg   <= p_q;
            inc2_reg <= inc_q;
            g2_reg   <= g_q;
            sat2_reg <= p_sat || inc_sat || g_sat;
        end
        if (s3_ready) begin
            op3_reg  <= op2_reg;
            p3_reg   <= p2_reg;
            sat3_reg <= sat2_reg || pole_sat || integ_sat || deriv_sat;
        end
        if (m_ready) begin
            if (op3_reg == OP_CLEAR) begin
                m_drive_reg <= '0;
                m_kind_reg  <= KIND_CLEAR_ACK;
                m_sat_reg   <= 1'b0;
            end else begin
                m_drive_reg <= drive_clip;
                m_kind_reg  <= KIND_DRIVE;
                m_sat_reg   <= sat3_reg || drive_sat;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(m_drive_reg);
    assign m_tuser  = {m_sat_reg, m_kind_reg};

    `PFD_ASSERT(a_clear_ack_clean,
        m_valid_reg && m_kind_reg == KIND_CLEAR_ACK |-> m_drive_reg == '0 && !m_sat_reg,
        "clear acknowledge carries drive or saturation")
    `PFD_ASSERT(a_cfg_clears_state,
        cfg_wr |=> prev_reg == '0 && integ_reg == '0 && deriv_reg == '0,
        "register write did not clear the regulator state")
    `PFD_ASSERT(a_clear_empties_integ,
        s2_valid_reg && s3_ready && op2_reg == OP_CLEAR && !cfg_wr
            |=> integ_reg == '0 && $stable(deriv_reg),
        "clear beat left integral or moved derivative")
    `PFD_ASSERT(a_stall_holds_state,
        s3_valid_reg && !m_ready && !cfg_wr |=> $stable(integ_reg) && $stable(deriv_reg),
        "state changed while the third stage was stalled")
    `PFD_ASSERT_ALWAYS(a_reset_empties,
        !aresetn |=> !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !m_valid_reg,
        "stage valid survived reset")

endmodule

// ----- tb/tb_pid_filtered_derivative_top.sv -----
module tb_pid_filtered_derivative_top;
    import pfd_pkg::*;

    localparam int  DATA_W      = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_WAIT  = 8;
    localparam int  HOLD_CYCLES = 200;
    localparam longint POLE_ONE = longint'(1) <<< GAIN_FRAC_BITS_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              kind;
        logic              clipped;
    } regulator_out_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // error_sample
    logic [0:0]            s_tuser  = '0;   // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;         // drive
    logic [1:0]            m_tuser;         // result_kind, saturated

    int cycle_count   = 0;
    int hold_until    = 0;
    int rx_stall_pct  = 0;
    int tx_idle_pct   = 0;
    int mismatch_count = 0;

    // Regulator settings and state as the block should hold them.
    longint kp_gain    = 0;
    longint int_gain   = 0;
    longint pole_value = 0;
    longint der_gain   = 0;
    longint prev_err   = 0;
    longint integ_acc  = 0;
    longint deriv_acc  = 0;
    logic   step_clipped;

    regulator_out_t regulator_out_q[$];

    pid_filtered_derivative_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count < hold_until) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        regulator_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (regulator_out_q.size() == 0) begin
                $error("result beat with no expected result, drive %h", m_tdata);
                mismatch_count++;
            end else begin
                want = regulator_out_q.pop_front();
                if (m_tdata !== want.drive) begin
                    $error("drive: expected %h, got %h", want.drive, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.kind) begin
                    $error("result_kind: expected %b, got %b", want.kind, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.clipped) begin
                    $error("saturated: expected %b, got %b", want.clipped, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic longint clip_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            step_clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            step_clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Exact product, floor shift by the gain fraction bits, clip to the accumulator.
    function automatic longint scale_gain(input longint a, input longint b);
        logic signed [127:0] prod;
        logic signed [127:0] shifted;
        prod    = $signed(128'(a)) * $signed(128'(b));
        shifted = prod >>> GAIN_FRAC_BITS_DEF;
        return clip_bits(longint'(shifted), ACC_W);
    endfunction

    task automatic predict_regulator(input logic op, input logic [DATA_W-1:0] sample);
        longint         e;
        longint         p;
        longint         inc;
        longint         dsum;
        longint         drv;
        longint         pole_eff;
        regulator_out_t r;
        if (op == OP_CLEAR) begin
            integ_acc = 0;
            r.drive   = '0;
            r.kind    = KIND_CLEAR_ACK;
            r.clipped = 1'b0;
        end else begin
            step_clipped = 1'b0;
            e        = longint'($signed(sample));
            pole_eff = (pole_value > POLE_ONE) ? POLE_ONE : pole_value;
            p        = scale_gain(kp_gain, e);
            inc      = scale_gain(int_gain, e + prev_err);
            integ_acc = clip_bits(integ_acc + inc, ACC_W);
            dsum     = scale_gain(pole_eff, deriv_acc) + scale_gain(der_gain, e - prev_err);
            deriv_acc = clip_bits(dsum, ACC_W);
            drv      = clip_bits(p + integ_acc + deriv_acc, SAMPLE_WIDTH_DEF);
            prev_err = e;
            r.drive   = DATA_W'(drv);
            r.kind    = KIND_DRIVE;
            r.clipped = step_clipped;
        end
        regulator_out_q.push_back(r);
    endtask

    task automatic send_beat(input logic op, input logic [DATA_W-1:0] sample);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_regulator(op, sample);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (regulator_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     kp_gain    = longint'($signed(value));
            REG_INTEGRAL_GAIN: int_gain   = longint'($signed(value));
            REG_DERIV_POLE:    pole_value = longint'(value[POLE_W-1:0]);
            REG_DERIV_GAIN:    der_gain   = longint'($signed(value));
            default: ;
        endcase
        prev_err  = 0;
        integ_acc = 0;
        deriv_acc = 0;
    endtask

    task automatic write_all(input logic [31:0] kp, input logic [31:0] gi,
                             input logic [31:0] pole, input logic [31:0] gd);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEGRAL_GAIN, gi);
        write_reg(REG_DERIV_POLE, pole);
        write_reg(REG_DERIV_GAIN, gd);
    endtask

    function automatic logic [31:0] random_gain();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            6, 7:    return $urandom();
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [31:0] random_pole();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'h0100_0000;
            2:       return $urandom();
            default: return 32'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_items(input int count);
        logic op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(9) == 0) ? OP_CLEAR : OP_REGULATE;
            send_beat(op, random_sample());
        end
    endtask

    task automatic test_reset_gains();
        send_beat(OP_REGULATE, 32'h7FFF_FFFF);
        send_beat(OP_REGULATE, 32'h8000_0000);
        send_beat(OP_CLEAR, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_directed_samples();
        write_all(32'h0100_0000, 32'h0040_0000, 32'h0080_0000, 32'hFE00_0000);
        send_beat(OP_REGULATE, 32'h0000_0000);
        send_beat(OP_REGULATE, 32'h0000_0001);
        send_beat(OP_REGULATE, 32'hFFFF_FFFF);
        send_beat(OP_REGULATE, 32'h0001_0000);
        send_beat(OP_CLEAR, 32'h1234_5678);
        send_beat(OP_CLEAR, 32'h0000_0000);
        send_beat(OP_REGULATE, 32'hFFFF_0000);
        send_beat(OP_REGULATE, 32'h7FFF_FFFF);
        send_beat(OP_REGULATE, 32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_pole_above_one();
        write_reg(REG_DERIV_POLE, 32'h01FF_FFFF);
        send_beat(OP_REGULATE, 32'h0010_0000);
        send_beat(OP_REGULATE, 32'h0000_0000);
        send_beat(OP_REGULATE, 32'h0000_0000);
        wait_idle();
        write_reg(REG_DERIV_POLE, 32'hFF00_0001);
        send_beat(OP_REGULATE, 32'hFFF0_0000);
        send_beat(OP_REGULATE, 32'h0000_0000);
        wait_idle();
    endtask

    task automatic test_drive_clipping();
        write_all(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_beat(OP_REGULATE, 32'h7FFF_FFFF);
        send_beat(OP_REGULATE, 32'h8000_0000);
        wait_idle();
        write_reg(REG_PROP_GAIN, 32'h8000_0000);
        send_beat(OP_REGULATE, 32'h7FFF_FFFF);
        send_beat(OP_REGULATE, 32'h8000_0000);
        wait_idle();
    endtask

    // Large error samples drive the integral into both of its limits.
    task automatic test_integral_windup();
        write_all(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        for (int i = 0; i < 270; i++) begin
            send_beat(OP_REGULATE, 32'($urandom_range(32'h7F00_0000, 32'h7FFF_FFFF)));
        end
        send_beat(OP_CLEAR, $urandom());
        wait_idle();
        write_reg(REG_INTEGRAL_GAIN, 32'h8000_0000);
        for (int i = 0; i < 270; i++) begin
            send_beat(OP_REGULATE, 32'($urandom_range(32'h7F00_0000, 32'h7FFF_FFFF)));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 45, 0, 6};
        rx_pct = '{0, 0, 45, 6};
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct <= rx_pct[ph];
            for (int sub = 0; sub < 2; sub++) begin
                write_all(random_gain(), random_gain(), random_pole(), random_gain());
                send_random_items(35);
                wait_idle();
            end
        end
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
    endtask

    task automatic test_output_hold();
        tx_idle_pct = 0;
        write_all(32'h0100_0000, 32'h0001_0000, 32'h00F0_0000, 32'h0080_0000);
        hold_until <= cycle_count + HOLD_CYCLES;
        send_random_items(40);
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_gains();
        test_directed_samples();
        test_pole_above_one();
        test_drive_clipping();
        test_integral_windup();
        test_random_traffic();
        test_output_hold();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_scaled_mul.sv
rtl/pid_filtered_derivative_top.sv
tb/tb_pid_filtered_derivative_top.sv
